### sv/gce_pkg.sv
// ----------------------------------------------------------------------------
// gce_pkg
// Shared types and constants for the graph coloring enumerator.
// ----------------------------------------------------------------------------
package gce_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int MAX_COLORS   = 16;

  localparam int VTX_W   = 6;
  localparam int IDX_W   = $clog2(MAX_VERTICES);
  localparam int CLR_W   = 5;
  localparam int SOL_W   = 32;
  localparam int CMD_W   = 2;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = VTX_W;

  localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND     = 2'd2;

  localparam logic [CFG_A_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_COLOR_COUNT  = 2'd1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [VTX_W-1:0] vertex;
    logic [CLR_W-1:0] color;
    logic [SOL_W-1:0] solution_number;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic add_edge;
    logic clear;
    logic step;
    logic emit_load;
    logic exhaust_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic exhausted;
    logic step_found;
    logic step_dead;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/graph_coloring_enumerator_unit.sv
// ----------------------------------------------------------------------------
// graph_coloring_enumerator_unit
// Enumerates proper colorings of a graph by depth-first backtracking.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    in_item_t (cmd, vertex_a, vertex_b)
//   out_     output     out_valid/out_ready  out_item_t (found .. last)
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// Add edge, clear and unused requests are taken in the idle state. A find
// request is taken there too, then steps (a color tried or a backtrack)
// until a coloring is found, giving one result per vertex, or the search
// dies and gives a single result, as an exhausted search does with no steps.
// Reset clears the adjacency store and colors at once; no clearing pass.
// A stalled output holds the sequencer in its emit or exhaust state until taken.
// ----------------------------------------------------------------------------
module graph_coloring_enumerator_unit
  import gce_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  gce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gce_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load || cmd.exhaust_load) |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.step, cmd.emit_load, cmd.exhaust_load, cmd.add_edge || cmd.clear}))
    else $error("conflicting datapath commands");

  a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.step)
    else $error("search step while accepting requests");

  a_exhaust_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> out_data.last)
    else $error("exhausted result not marked last");

endmodule

### sv/gce_ctrl.sv
// ----------------------------------------------------------------------------
// gce_ctrl
// Sequencer for request intake, search stepping and result emission.
// ----------------------------------------------------------------------------
module gce_ctrl
  import gce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  dp_stat_t         stat,
  output ctrl_cmd_t        cmd
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SEARCH  = 4'b0010,
    ST_EMIT    = 4'b0100,
    ST_EXHAUST = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_ADD_EDGE: cmd.add_edge = 1'b1;
            CMD_CLEAR:    cmd.clear = 1'b1;
            CMD_FIND: begin
              state_nxt = stat.exhausted ? ST_EXHAUST : ST_SEARCH;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (stat.step_found) begin
          state_nxt = ST_EMIT;
        end else if (stat.step_dead) begin
          state_nxt = ST_EXHAUST;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EXHAUST: begin
        if (stat.out_free) begin
          cmd.exhaust_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/gce_dp.sv
// ----------------------------------------------------------------------------
// gce_dp
// Adjacency store, color stack, search step logic and result register.
// ----------------------------------------------------------------------------
module gce_dp
  import gce_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data,
  input  in_item_t           in_data,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  input  logic               out_ready,
  output logic               out_valid,
  output out_item_t          out_data
);

  typedef enum logic [1:0] {
    PH_FRESH     = 2'd0,
    PH_RUNNING   = 2'd1,
    PH_EXHAUSTED = 2'd2
  } phase_t;

  logic [MAX_VERTICES-1:0] adj_r    [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_nxt  [MAX_VERTICES];
  logic [CLR_W-1:0]        colors_r [MAX_VERTICES];
  logic [CLR_W-1:0]        colors_nxt [MAX_VERTICES];

  logic [VTX_W-1:0] vc_r, vc_nxt;
  logic [CLR_W-1:0] cc_r, cc_nxt;
  logic [IDX_W-1:0] depth_r, depth_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SOL_W-1:0] sol_r, sol_nxt;
  phase_t           phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [VTX_W-1:0] used_v;
  logic [VTX_W-1:0] used_v_m1;
  logic [IDX_W-1:0] last_idx;
  logic [CLR_W-1:0] used_c;
  logic [IDX_W-1:0] rd_idx;
  logic [CLR_W-1:0] rd_color;
  logic [CLR_W-1:0] cand;
  logic             over;
  logic             conflict;
  logic             fits;
  logic [VTX_W-1:0] a_m1, b_m1;
  logic [IDX_W-1:0] a_idx, b_idx;
  logic             edge_ok;
  logic             restart;

  always_comb begin
    if (vc_r == '0) begin
      used_v = VTX_W'(1);
    end else if (vc_r > VTX_W'(MAX_VERTICES)) begin
      used_v = VTX_W'(MAX_VERTICES);
    end else begin
      used_v = vc_r;
    end
    used_v_m1 = used_v - VTX_W'(1);
    last_idx  = used_v_m1[IDX_W-1:0];
    used_c    = (cc_r > CLR_W'(MAX_COLORS)) ? CLR_W'(MAX_COLORS) : cc_r;
  end

  assign rd_idx   = cmd.emit_load ? idx_r : depth_r;
  assign rd_color = colors_r[rd_idx];
  assign cand     = rd_color + CLR_W'(1);
  assign over     = cand > used_c;

  always_comb begin
    conflict = 1'b0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if ((IDX_W'(j) < depth_r) && adj_r[depth_r][j] && (colors_r[j] == cand)) begin
        conflict = 1'b1;
      end
    end
  end

  assign fits = !conflict;

  assign a_m1    = in_data.vertex_a - VTX_W'(1);
  assign b_m1    = in_data.vertex_b - VTX_W'(1);
  assign a_idx   = a_m1[IDX_W-1:0];
  assign b_idx   = b_m1[IDX_W-1:0];
  assign edge_ok = (in_data.vertex_a != '0) && (in_data.vertex_a <= VTX_W'(MAX_VERTICES)) &&
                   (in_data.vertex_b != '0) && (in_data.vertex_b <= VTX_W'(MAX_VERTICES));

  assign stat.exhausted  = (phase_r == PH_EXHAUSTED);
  assign stat.step_found = !over && fits && (depth_r == last_idx);
  assign stat.step_dead  = over && (depth_r == '0);
  assign stat.emit_last  = (idx_r == last_idx);
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    adj_nxt       = adj_r;
    colors_nxt    = colors_r;
    vc_nxt        = vc_r;
    cc_nxt        = cc_r;
    depth_nxt     = depth_r;
    idx_nxt       = idx_r;
    sol_nxt       = sol_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    restart       = 1'b0;

    if (cfg_we) begin
      if (cfg_index == CFG_VERTEX_COUNT) begin
        vc_nxt  = cfg_data[VTX_W-1:0];
        restart = 1'b1;
      end else if (cfg_index == CFG_COLOR_COUNT) begin
        cc_nxt  = cfg_data[CLR_W-1:0];
        restart = 1'b1;
      end
    end

    if (cmd.add_edge) begin
      restart = 1'b1;
      if (edge_ok) begin
        adj_nxt[a_idx][b_idx] = 1'b1;
        adj_nxt[b_idx][a_idx] = 1'b1;
      end
    end

    if (cmd.clear) begin
      restart = 1'b1;
      for (int k = 0; k < MAX_VERTICES; k++) begin
        adj_nxt[k] = '0;
      end
    end

    if (cmd.step) begin
      if (over) begin
        colors_nxt[depth_r] = '0;
        if (depth_r == '0) begin
          phase_nxt = PH_EXHAUSTED;
        end else begin
          depth_nxt = depth_r - IDX_W'(1);
        end
      end else begin
        colors_nxt[depth_r] = cand;
        if (fits) begin
          if (depth_r == last_idx) begin
            phase_nxt = PH_RUNNING;
            idx_nxt   = '0;
            if (sol_r != '1) begin
              sol_nxt = sol_r + SOL_W'(1);
            end
          end else begin
            depth_nxt = depth_r + IDX_W'(1);
            colors_nxt[depth_r + IDX_W'(1)] = '0;
          end
        end
      end
    end

    if (cmd.emit_load) begin
      idx_nxt                      = idx_r + IDX_W'(1);
      out_valid_nxt                = 1'b1;
      out_data_nxt.found           = 1'b1;
      out_data_nxt.vertex          = VTX_W'(idx_r) + VTX_W'(1);
      out_data_nxt.color           = rd_color;
      out_data_nxt.solution_number = sol_r;
      out_data_nxt.last            = (idx_r == last_idx);
    end

    if (cmd.exhaust_load) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.found           = 1'b0;
      out_data_nxt.vertex          = '0;
      out_data_nxt.color           = '0;
      out_data_nxt.solution_number = sol_r;
      out_data_nxt.last            = 1'b1;
    end

    if (restart) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
        colors_nxt[k] = '0;
      end
      depth_nxt = '0;
      sol_nxt   = '0;
      phase_nxt = PH_FRESH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_VERTICES; k++) begin
        adj_r[k]    <= '0;
        colors_r[k] <= '0;
      end
      vc_r        <= VTX_W'(1);
      cc_r        <= CLR_W'(1);
      depth_r     <= '0;
      idx_r       <= '0;
      sol_r       <= '0;
      phase_r     <= PH_FRESH;
      out_valid_r <= 1'b0;
    end else begin
      adj_r       <= adj_nxt;
      colors_r    <= colors_nxt;
      vc_r        <= vc_nxt;
      cc_r        <= cc_nxt;
      depth_r     <= depth_nxt;
      idx_r       <= idx_nxt;
      sol_r       <= sol_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### verif/gce_checker.sv
// ----------------------------------------------------------------------------
// gce_checker
// Watches the request, result and register ports of the coloring enumerator,
// predicts every result of the backtracking search and compares each field.
// ----------------------------------------------------------------------------
module gce_checker
  import gce_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_item_t          out_data,
  output int unsigned        fail_count,
  output int unsigned        pending_results,
  output int unsigned        requests_seen,
  output int unsigned        colorings_seen,
  output int unsigned        exhausted_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    SEARCH_FRESH,
    SEARCH_RUNNING,
    SEARCH_EXHAUSTED
  } search_phase_t;

  logic [MAX_VERTICES-1:0] neighbors [MAX_VERTICES];
  int unsigned             vertex_hue [MAX_VERTICES];
  int unsigned             cur_depth;
  logic [SOL_W-1:0]        solutions;
  search_phase_t           phase;
  logic [VTX_W-1:0]        vertex_count;
  logic [CLR_W-1:0]        color_count;
  out_item_t               expected_colorings [$];

  function automatic void restart_search();
    foreach (vertex_hue[i]) vertex_hue[i] = 0;
    cur_depth = 1;
    solutions = '0;
    phase = SEARCH_FRESH;
  endfunction

  function automatic int unsigned vertices_in_use();
    if (vertex_count == 0) return 1;
    if (vertex_count > MAX_VERTICES) return MAX_VERTICES;
    return 32'(vertex_count);
  endfunction

  function automatic int unsigned colors_in_use();
    return (color_count > MAX_COLORS) ? MAX_COLORS : 32'(color_count);
  endfunction

  function automatic bit hue_is_legal(int unsigned t);
    for (int unsigned j = 1; j < t; j++) begin
      if (neighbors[t-1][j-1] && vertex_hue[j-1] == vertex_hue[t-1]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit advance_search();
    int unsigned n;
    int unsigned m;
    int unsigned t;
    int unsigned c;
    n = vertices_in_use();
    m = colors_in_use();
    t = cur_depth;
    if (t < 1 || t > n) t = 1;
    while (t >= 1) begin
      c = vertex_hue[t-1] + 1;
      if (c > m) begin
        vertex_hue[t-1] = 0;
        t--;
        continue;
      end
      vertex_hue[t-1] = c;
      if (hue_is_legal(t)) begin
        if (t == n) begin
          cur_depth = t;
          return 1'b1;
        end
        t++;
        vertex_hue[t-1] = 0;
      end
    end
    cur_depth = 1;
    return 1'b0;
  endfunction

  function automatic void predict_coloring_results(in_item_t req);
    int unsigned n;
    out_item_t   res;
    case (req.cmd)
      CMD_ADD_EDGE: begin
        if (req.vertex_a >= 1 && req.vertex_a <= MAX_VERTICES &&
            req.vertex_b >= 1 && req.vertex_b <= MAX_VERTICES) begin
          neighbors[req.vertex_a - 1][req.vertex_b - 1] = 1'b1;
          neighbors[req.vertex_b - 1][req.vertex_a - 1] = 1'b1;
        end
        restart_search();
      end
      CMD_CLEAR: begin
        foreach (neighbors[i]) neighbors[i] = '0;
        restart_search();
      end
      CMD_FIND: begin
        if (phase != SEARCH_EXHAUSTED && advance_search()) begin
          n = vertices_in_use();
          phase = SEARCH_RUNNING;
          if (solutions != '1) solutions++;
          for (int unsigned i = 0; i < n; i++) begin
            res.found = 1'b1;
            res.vertex = VTX_W'(i + 1);
            res.color = CLR_W'(vertex_hue[i]);
            res.solution_number = solutions;
            res.last = (i + 1 == n);
            expected_colorings.push_back(res);
          end
        end else begin
          phase = SEARCH_EXHAUSTED;
          res = '0;
          res.solution_number = solutions;
          res.last = 1'b1;
          expected_colorings.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [SOL_W-1:0] want,
                             input logic [SOL_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (neighbors[i]) neighbors[i] = '0;
      vertex_count = 1;
      color_count = 1;
      restart_search();
      expected_colorings.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_colorings.size() == 0) begin
          $error("result with no request waiting: vertex %0d color %0d",
                 out_data.vertex, out_data.color);
          fail_count++;
        end else begin
          want = expected_colorings.pop_front();
          check_field("found", SOL_W'(want.found), SOL_W'(out_data.found));
          check_field("vertex", SOL_W'(want.vertex), SOL_W'(out_data.vertex));
          check_field("color", SOL_W'(want.color), SOL_W'(out_data.color));
          check_field("solution_number", want.solution_number, out_data.solution_number);
          check_field("last", SOL_W'(want.last), SOL_W'(out_data.last));
          if (!want.found) exhausted_seen++;
          else if (want.last) colorings_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERTEX_COUNT: begin
            vertex_count = cfg_data;
            restart_search();
          end
          CFG_COLOR_COUNT: begin
            color_count = cfg_data[CLR_W-1:0];
            restart_search();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        requests_seen++;
        predict_coloring_results(in_data);
      end
    end
    pending_results = expected_colorings.size();
  end

endmodule

### verif/tb_graph_coloring_enumerator_unit.sv
// ----------------------------------------------------------------------------
// tb_graph_coloring_enumerator_unit
// Drives edge, clear, find and unused requests plus register writes into the
// enumerator, with bursty requests, a stalling receiver and one long hold-off.
// ----------------------------------------------------------------------------
module tb_graph_coloring_enumerator_unit
  import gce_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0]   CMD_UNUSED    = 2'd3;
  localparam logic [CFG_A_W-1:0] CFG_SPARE_A   = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_SPARE_B   = 2'd3;
  localparam int                 SETTLE_CYCLES = 16;
  localparam int                 HOLD_CYCLES   = 400;
  localparam int                 QUIET_LIMIT   = 200000;
  localparam int                 ITEM_TARGET   = 110;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_index;
  logic [CFG_D_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned requests_seen;
  int unsigned colorings_seen;
  int unsigned exhausted_seen;

  int unsigned burst_left;
  int unsigned item_count;
  int unsigned quiet_cycles;
  bit          hold_req;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  graph_coloring_enumerator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gce_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .requests_seen   (requests_seen),
    .colorings_seen  (colorings_seen),
    .exhausted_seen  (exhausted_seen)
  );

  task automatic send_request(input logic [CMD_W-1:0] cmd, input int unsigned a,
                              input int unsigned b);
    in_item_t req;
    req.cmd = cmd;
    req.vertex_a = VTX_W'(a);
    req.vertex_b = VTX_W'(b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    if (cmd != CMD_UNUSED) item_count++;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_A_W-1:0] idx, input int unsigned val);
    settle_block();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_D_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned odds;
    bit          held;
    out_ready = 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      odds = $urandom_range(1, 4);
      repeat ($urandom_range(1, 40)) begin
        @(negedge clk);
        out_ready <= ($urandom_range(1, 4) <= odds);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAIL graph_coloring_enumerator_unit");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned m;
    int unsigned r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    item_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(CMD_FIND, 0, 0);
    send_request(CMD_FIND, 0, 0);
    send_request(CMD_FIND, 63, 63);
    write_register(CFG_VERTEX_COUNT, 3);
    write_register(CFG_COLOR_COUNT, 2);
    send_request(CMD_ADD_EDGE, 1, 2);
    send_request(CMD_ADD_EDGE, 2, 3);
    send_request(CMD_ADD_EDGE, 3, 3);
    send_request(CMD_ADD_EDGE, 0, 5);
    send_request(CMD_ADD_EDGE, 63, 63);
    send_request(CMD_ADD_EDGE, 33, 2);
    repeat (3) send_request(CMD_FIND, 0, 0);
    send_request(CMD_UNUSED, 63, 0);
    send_request(CMD_FIND, 0, 0);
    send_request(CMD_CLEAR, 0, 0);
    send_request(CMD_FIND, 0, 0);
    send_request(CMD_ADD_EDGE, 5, 6);
    send_request(CMD_FIND, 0, 0);
    write_register(CFG_COLOR_COUNT, 0);
    send_request(CMD_FIND, 0, 0);
    write_register(CFG_VERTEX_COUNT, 0);
    write_register(CFG_COLOR_COUNT, 63);
    send_request(CMD_FIND, 0, 0);
    write_register(CFG_SPARE_A, 5);
    write_register(CFG_SPARE_B, 63);
    send_request(CMD_FIND, 0, 0);
    write_register(CFG_VERTEX_COUNT, 63);
    write_register(CFG_COLOR_COUNT, 16);
    send_request(CMD_CLEAR, 63, 63);
    send_request(CMD_ADD_EDGE, 1, 32);
    repeat (2) send_request(CMD_FIND, 0, 0);
    write_register(CFG_COLOR_COUNT, 1);
    send_request(CMD_FIND, 0, 0);

    write_register(CFG_VERTEX_COUNT, 4);
    write_register(CFG_COLOR_COUNT, 2);
    send_request(CMD_CLEAR, 0, 0);
    hold_req = 1'b1;
    repeat (12) send_request(CMD_FIND, $urandom_range(0, 63), $urandom_range(0, 63));

    while (item_count < ITEM_TARGET) begin
      n = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) begin
        write_register(CFG_VERTEX_COUNT, 0);
        n = 1;
      end else begin
        write_register(CFG_VERTEX_COUNT, n);
      end
      r = $urandom_range(0, 9);
      m = (r == 0) ? 0 : (r == 1) ? $urandom_range(17, 31) : $urandom_range(1, 4);
      write_register(CFG_COLOR_COUNT, m + 32 * $urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
        write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom_range(0, 63));
      end
      if ($urandom_range(0, 1)) begin
        send_request(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
      end
      repeat ($urandom_range(0, n + 2)) begin
        send_request(CMD_ADD_EDGE, $urandom_range(1, n), $urandom_range(1, n));
      end
      repeat ($urandom_range(2, 8)) begin
        send_request(CMD_FIND, $urandom_range(0, 63), $urandom_range(0, 63));
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_request(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                       $urandom_range(0, 63));
        end
        repeat ($urandom_range(1, 4)) send_request(CMD_FIND, 0, 0);
      end
    end

    settle_block();
    $display("Run covered %0d requests; %0d colorings and %0d exhausted replies were checked.",
             requests_seen, colorings_seen, exhausted_seen);
    $display("Register extremes, ignored edges and a %0d-cycle receiver hold-off were included.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS graph_coloring_enumerator_unit");
    end else begin
      $display("FAIL graph_coloring_enumerator_unit");
    end
    $finish;
  end

endmodule
